### rtl/lsdp_pkg.sv
// Shared types, constants and lookup tables for the line sensor debounce block.
// Used by lsdp_lane, lsdp_merge and line_sensor_debounce_position_core.
package lsdp_pkg;

   localparam int SENSOR_COUNT = 4;

   // Register indexes, decoded from csr_paddr[2]
   localparam logic CSR_FILTER_LENGTH = 1'b0;
   localparam logic CSR_BLACK_IS_HIGH = 1'b1;

   localparam logic [3:0] FILTER_LENGTH_RESET = 4'd3;
   localparam logic       BLACK_IS_HIGH_RESET = 1'b1;

   localparam logic [SENSOR_COUNT-1:0] ALL_BLACK_PATTERN = 4'hF;
   localparam logic [SENSOR_COUNT-1:0] ALL_WHITE_PATTERN = 4'h0;

   // Configuration seen by every lane
   typedef struct packed {
      logic [3:0] filter_length;
      logic       black_is_high;
   } lsdp_cfg_type;

   // One result as produced by the merging stage
   typedef struct packed {
      logic              all_black;
      logic              all_white;
      logic              on_line;
      logic signed [2:0] line_error;
      logic [3:0]        filtered_bits;
   } lsdp_result_type;

   // Average weight of the set bits (weights -3,-1,+1,+3 from bit 3 down to
   // bit 0), truncated toward zero, indexed by the filtered pattern.
   localparam logic signed [2:0] LINE_ERROR_TABLE [16] = '{
      3'sd0,  3'sd3,  3'sd1,  3'sd2,
      -3'sd1, 3'sd1,  3'sd0,  3'sd1,
      -3'sd3, 3'sd0,  -3'sd1, 3'sd0,
      -3'sd2, 3'sd0,  -3'sd1, 3'sd0
   };

endpackage

### rtl/lsdp_lane.sv
// One sensor lane: polarity correction, saturating integrator and hysteresis bit.
// Depends on lsdp_pkg for the configuration struct.
module lsdp_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  sensor_level,
   input  lsdp_pkg::lsdp_cfg_type cfg,
   output logic                  filtered_bit
);
   import lsdp_pkg::*;

   logic [3:0] count_ff, count_in;
   logic       filt_ff, filt_in;
   logic       on_black;

   // A sample is black when its level matches the configured polarity.
   assign on_black = cfg.black_is_high ? sensor_level : ~sensor_level;

   // Count toward the top on black, toward zero on white, then apply hysteresis.
   always_comb begin
      count_in = count_ff;
      filt_in  = filt_ff;
      if (on_black) begin
         if (count_ff < cfg.filter_length) begin
            count_in = count_ff + 4'd1;
         end
         if (count_in >= cfg.filter_length) begin
            filt_in = 1'b1;
         end
      end else begin
         if (count_ff != 4'd0) begin
            count_in = count_ff - 4'd1;
         end
         if (count_in == 4'd0) begin
            filt_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         filt_ff  <= 1'b0;
      end else if (enable) begin
         count_ff <= count_in;
         filt_ff  <= filt_in;
      end
   end

   // The merging stage sees the bit as it will be after this request.
   assign filtered_bit = enable ? filt_in : filt_ff;

endmodule

### rtl/lsdp_merge.sv
// Merging stage: combines the lane bits into flags and the weighted line error.
// Depends on lsdp_pkg for the result struct, patterns and the error table.
module lsdp_merge (
   input  logic [lsdp_pkg::SENSOR_COUNT-1:0] lane_bits,
   output lsdp_pkg::lsdp_result_type         result
);
   import lsdp_pkg::*;

   // The error table already folds in the zero answer for no active sensor.
   always_comb begin
      result.filtered_bits = lane_bits;
      result.line_error    = LINE_ERROR_TABLE[lane_bits];
      result.on_line       = (lane_bits != ALL_WHITE_PATTERN);
      result.all_white     = (lane_bits == ALL_WHITE_PATTERN);
      result.all_black     = (lane_bits == ALL_BLACK_PATTERN);
   end

endmodule

### rtl/line_sensor_debounce_position_core.sv
// Top level of the line sensor debounce and position block.
// Depends on lsdp_pkg, lsdp_lane and lsdp_merge.

// The block takes one 4-bit sensor sample per request and returns one result per
// request, in the cycle after acceptance; it sustains one request per clock cycle
// while results are taken, as the four sensor lanes each update their integrator
// per request and the merging stage is a small lookup. The output register
// decouples the sides: a new request is accepted while the previous result is
// being taken. The filter length and polarity registers are written over the
// APB-style port and should only be changed while no result is pending.
module line_sensor_debounce_position_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] raw_levels, [7:4] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] filtered_bits, [6:4] line_error,
                                    // [7] on_line, [8] all_white, [9] all_black,
                                    // [15:10] zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lsdp_pkg::*;

   lsdp_cfg_type                cfg_ff;
   logic                        csr_write;
   logic                        req_accept;
   logic [SENSOR_COUNT-1:0]     lane_bits;
   lsdp_result_type             merged;
   lsdp_result_type             rsp_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_length <= FILTER_LENGTH_RESET;
         cfg_ff.black_is_high <= BLACK_IS_HIGH_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_FILTER_LENGTH: cfg_ff.filter_length <= csr_pwdata[3:0];
            CSR_BLACK_IS_HIGH: cfg_ff.black_is_high <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back the selected register.
   always_comb begin
      case (csr_paddr[2])
         CSR_FILTER_LENGTH: csr_prdata = {28'd0, cfg_ff.filter_length};
         CSR_BLACK_IS_HIGH: csr_prdata = {31'd0, cfg_ff.black_is_high};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Accept a request whenever the output register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // One lane per sensor
   for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
      lsdp_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .enable       (req_accept),
         .sensor_level (req_tdata[i]),
         .cfg          (cfg_ff),
         .filtered_bit (lane_bits[i])
      );
   end

   lsdp_merge u_merge (
      .lane_bits (lane_bits),
      .result    (merged)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= merged;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.all_black, rsp_ff.all_white, rsp_ff.on_line,
                        rsp_ff.line_error, rsp_ff.filtered_bits};

   // An accepted request always leaves a result waiting in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   // The filtered state moves only when a request is accepted; the lane bits
   // already show the next state in a cycle that accepts one.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> (req_accept || $stable(lane_bits)))
      else $error("filtered bits changed without a request");

   // All sensors black is a centered line.
   a_all_black_centered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.all_black) |-> (rsp_ff.line_error == 3'sd0))
      else $error("all black result with nonzero line error");

   // A result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while result stalled");

endmodule
